// File: hw/rtl/fifo_with_prefix_reverse_unit_assert.svh
// Assertion helpers for the prefix-reverse FIFO.
// Both macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef FIFO_WITH_PREFIX_REVERSE_UNIT_ASSERT_SVH
`define FIFO_WITH_PREFIX_REVERSE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPR_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fpr_pkg.sv
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQ = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REV = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_MANY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SW_RD_LO,
        ST_SW_RD_HI,
        ST_SW_WR_LO,
        ST_SW_WR_HI,
        ST_HEAD_RD,
        ST_HEAD_DONE
    } seq_state_t;

endpackage

// File: hw/rtl/fpr_in_if.sv
`timescale 1ns / 1ps

interface fpr_in_if;
    logic                               valid;
    logic                               ready;
    logic [fpr_pkg::ACTION_W-1:0]       action;
    logic [fpr_pkg::VALUE_W-1:0]        entry_value;
    logic [fpr_pkg::COUNT_W-1:0]        reverse_count;

    modport source (output valid, output action, output entry_value,
                    output reverse_count, input ready);
    modport sink   (input valid, input action, input entry_value,
                    input reverse_count, output ready);
endinterface

// File: hw/rtl/fpr_out_if.sv
`timescale 1ns / 1ps

interface fpr_out_if;
    logic                               valid;
    logic                               ready;
    logic                               head_valid;
    logic [fpr_pkg::VALUE_W-1:0]        head_value;
    logic [fpr_pkg::COUNT_W-1:0]        occupancy;
    logic [fpr_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output head_valid, output head_value,
                    output occupancy, output status, input ready);
    modport sink   (input valid, input head_valid, input head_value,
                    input occupancy, input status, output ready);
endinterface

// File: hw/rtl/fpr_ram.sv
`timescale 1ns / 1ps

module fpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// File: hw/rtl/fpr_addr.sv
`timescale 1ns / 1ps

// Maps an offset from the head to a physical slot, wrapping modulo DEPTH.
// Both operands are below DEPTH, so one conditional subtract suffices.
module fpr_addr #(
    parameter int DEPTH = 128
) (
    input  logic [$clog2(DEPTH)-1:0]   base,
    input  logic [$clog2(DEPTH+1)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0]   slot
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(DEPTH);

    logic [CNT_W:0] sum;
    logic [CNT_W:0] wrapped;

    always_comb
    begin
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
        if (sum >= DEPTH_C)
        begin
            wrapped = sum - DEPTH_C;
        end
        else
        begin
            wrapped = sum;
        end
        slot = wrapped[IDX_W-1:0];
    end

endmodule

// File: hw/rtl/fifo_with_prefix_reverse_unit.sv
`timescale 1ns / 1ps
// Channel  Port  Word contents
// -------  ----  --------------------------------------------------
// command  cmd   action, entry_value, reverse_count
// result   rsp   head_valid, head_value, occupancy, status
//
// Enqueue, dequeue and rejected commands pass from accept through EXEC, HEAD_RD and HEAD_DONE
// back to IDLE before the next accept. A reverse of k >= 2 entries adds floor(k/2) swaps, each a
// pass through SW_RD_LO, SW_RD_HI, SW_WR_LO and SW_WR_HI. The sequence is set by the entry RAM, on
// one shared address (one read and one write per cycle), and the one slot adder every access uses.
// Reset empties the queue at once; entry contents are not cleared.
// cmd is ready only between commands; a stalled result holds back the next one.

`include "fifo_with_prefix_reverse_unit_assert.svh"

module fifo_with_prefix_reverse_unit #(
    parameter int DEPTH   = 128,
    parameter int ENTRY_W = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    fpr_in_if.sink      cmd,
    fpr_out_if.source   rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > fpr_pkg::COUNT_W) ? CNT_W : fpr_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [fpr_pkg::COUNT_W-1:0] OCC_FULL = fpr_pkg::COUNT_W'(DEPTH);

    fpr_pkg::seq_state_t state_reg, state_next;

    logic [fpr_pkg::ACTION_W-1:0] action_reg;
    logic [ENTRY_W-1:0]           value_reg;
    logic [fpr_pkg::COUNT_W-1:0]  k_reg;

    logic [IDX_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             lo_reg, lo_next;
    logic [CNT_W-1:0]             hi_reg, hi_next;
    logic [ENTRY_W-1:0]           tmp_reg, tmp_next;
    logic [fpr_pkg::STATUS_W-1:0] stat_reg, stat_next;

    logic                         rsp_valid_reg;
    logic                         head_valid_reg;
    logic [fpr_pkg::VALUE_W-1:0]  head_value_reg;
    logic [fpr_pkg::COUNT_W-1:0]  occupancy_reg;
    logic [fpr_pkg::STATUS_W-1:0] status_reg;

    logic [CNT_W-1:0]             offset;
    logic [IDX_W-1:0]             slot;
    logic                         ram_we;
    logic [ENTRY_W-1:0]           ram_wdata;
    logic [ENTRY_W-1:0]           rd_data;

    logic                         too_many;
    logic                         rev_go;
    logic                         swap_more;
    logic                         rsp_load;

    fpr_addr #(
        .DEPTH (DEPTH)
    ) u_addr (
        .base   (head_reg),
        .offset (offset),
        .slot   (slot)
    );

    fpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (ram_wdata),
        .raddr (slot),
        .rdata (rd_data)
    );

    assign too_many  = CMP_W'(k_reg) > CMP_W'(count_reg);
    assign rev_go    = (action_reg == fpr_pkg::ACT_REV) && !too_many && (k_reg > 8'd1);
    assign swap_more = (lo_reg + CNT_W'(1)) < (hi_reg - CNT_W'(1));
    assign rsp_load  = (state_reg == fpr_pkg::ST_HEAD_DONE) && (!rsp_valid_reg || rsp.ready);

    assign cmd.ready      = (state_reg == fpr_pkg::ST_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.head_valid = head_valid_reg;
    assign rsp.head_value = head_value_reg;
    assign rsp.occupancy  = occupancy_reg;
    assign rsp.status     = status_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpr_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = fpr_pkg::ST_EXEC;
                end
            end
            fpr_pkg::ST_EXEC:
            begin
                state_next = rev_go ? fpr_pkg::ST_SW_RD_LO : fpr_pkg::ST_HEAD_RD;
            end
            fpr_pkg::ST_SW_RD_LO: state_next = fpr_pkg::ST_SW_RD_HI;
            fpr_pkg::ST_SW_RD_HI: state_next = fpr_pkg::ST_SW_WR_LO;
            fpr_pkg::ST_SW_WR_LO: state_next = fpr_pkg::ST_SW_WR_HI;
            fpr_pkg::ST_SW_WR_HI:
            begin
                state_next = swap_more ? fpr_pkg::ST_SW_RD_LO : fpr_pkg::ST_HEAD_RD;
            end
            fpr_pkg::ST_HEAD_RD: state_next = fpr_pkg::ST_HEAD_DONE;
            fpr_pkg::ST_HEAD_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = fpr_pkg::ST_IDLE;
                end
            end
            default: state_next = fpr_pkg::ST_IDLE;
        endcase
    end

    // The slot adder defaults to the head, so the head entry is what the RAM
    // presents whenever no other access is under way.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tmp_next   = tmp_reg;
        stat_next  = stat_reg;
        offset     = '0;
        ram_we     = 1'b0;
        ram_wdata  = rd_data;
        case (state_reg)
            fpr_pkg::ST_IDLE:
            begin
                stat_next = fpr_pkg::STAT_OK;
            end
            fpr_pkg::ST_EXEC:
            begin
                case (action_reg)
                    fpr_pkg::ACT_ENQ:
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            stat_next = fpr_pkg::STAT_FULL;
                        end
                        else
                        begin
                            offset     = count_reg;
                            ram_we     = 1'b1;
                            ram_wdata  = value_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    fpr_pkg::ACT_DEQ:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = fpr_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            offset     = CNT_W'(1);
                            head_next  = slot;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    fpr_pkg::ACT_REV:
                    begin
                        if (too_many)
                        begin
                            stat_next = fpr_pkg::STAT_TOO_MANY;
                        end
                        else
                        begin
                            lo_next = '0;
                            hi_next = CNT_W'(k_reg) - CNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            fpr_pkg::ST_SW_RD_LO:
            begin
                offset = lo_reg;
            end
            fpr_pkg::ST_SW_RD_HI:
            begin
                // The low entry arrives now; keep it while the high one is read.
                offset   = hi_reg;
                tmp_next = rd_data;
            end
            fpr_pkg::ST_SW_WR_LO:
            begin
                offset    = lo_reg;
                ram_we    = 1'b1;
                ram_wdata = rd_data;
            end
            fpr_pkg::ST_SW_WR_HI:
            begin
                offset    = hi_reg;
                ram_we    = 1'b1;
                ram_wdata = tmp_reg;
                lo_next   = lo_reg + CNT_W'(1);
                hi_next   = hi_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpr_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            stat_reg      <= fpr_pkg::STAT_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            stat_reg  <= stat_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        tmp_reg <= tmp_next;
        if (cmd.valid && cmd.ready)
        begin
            action_reg <= cmd.action;
            value_reg  <= cmd.entry_value[ENTRY_W-1:0];
            k_reg      <= cmd.reverse_count;
        end
        if (rsp_load)
        begin
            head_valid_reg <= (count_reg != '0);
            head_value_reg <= (count_reg != '0) ? fpr_pkg::VALUE_W'(rd_data) : '0;
            occupancy_reg  <= fpr_pkg::COUNT_W'(count_reg);
            status_reg     <= stat_reg;
        end
    end

    `FPR_CHECK_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C, "occupancy above depth")
    `FPR_CHECK_NEXT(a_accept_exec, cmd.valid && cmd.ready, state_reg == fpr_pkg::ST_EXEC, "accepted word not executed")
    `FPR_CHECK_NOW(a_swap_order, state_reg == fpr_pkg::ST_SW_RD_LO, lo_reg < hi_reg, "swap pointers crossed")
    `FPR_CHECK_NEXT(a_swap_count, state_reg == fpr_pkg::ST_SW_WR_HI, $stable(count_reg), "occupancy moved during reverse")
    `FPR_CHECK_NOW(a_full_occ, rsp.valid && (rsp.status == fpr_pkg::STAT_FULL), rsp.occupancy == OCC_FULL, "full status without full occupancy")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fpr_pkg::*;

    localparam int DEPTH = 128;
    localparam int ENTRY_W = 64;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD_CYCLES = 200;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  rev_count;
    } fifo_cmd_t;

    typedef struct packed {
        logic                head_valid;
        logic [VALUE_W-1:0]  head_value;
        logic [COUNT_W-1:0]  occupancy;
        logic [STATUS_W-1:0] status;
    } fifo_view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    fpr_in_if  cmd_if ();
    fpr_out_if rsp_if ();

    fifo_with_prefix_reverse_unit #(
        .DEPTH   (DEPTH),
        .ENTRY_W (ENTRY_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #2 clk = ~clk;

    // Shadow copy of the queue state.
    logic [VALUE_W-1:0] shadow_entries [DEPTH];
    logic [6:0]         shadow_head = '0;
    int                 shadow_count = 0;

    fifo_cmd_t  pending_cmds [$];
    fifo_view_t expected_views [$];
    fifo_cmd_t  issue_cmd;
    fifo_view_t want;

    int plan_count = 0;
    int mismatches = 0;
    int views_checked;
    int burst_left;
    int gap_left;
    int hold_left;
    int holds_done;
    logic [31:0] rx_cycle;
    logic rx_go;

    int n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0;
    int n_rev = 0, n_too_many = 0, n_nop = 0, peak_count = 0;

    function automatic fifo_view_t apply_command(input fifo_cmd_t c);
        fifo_view_t v;
        int lo;
        int hi;
        logic [6:0] sa;
        logic [6:0] sb;
        logic [VALUE_W-1:0] tmp;
        v.status = STAT_OK;
        case (c.action)
            ACT_ENQ:
            begin
                n_enq++;
                if (shadow_count >= DEPTH)
                begin
                    v.status = STAT_FULL;
                    n_full++;
                end
                else
                begin
                    sa = shadow_head + 7'(shadow_count);
                    shadow_entries[sa] = c.value;
                    shadow_count++;
                end
            end
            ACT_DEQ:
            begin
                n_deq++;
                if (shadow_count == 0)
                begin
                    v.status = STAT_EMPTY;
                    n_empty++;
                end
                else
                begin
                    shadow_head = shadow_head + 7'd1;
                    shadow_count--;
                end
            end
            ACT_REV:
            begin
                n_rev++;
                if (int'(c.rev_count) > shadow_count)
                begin
                    v.status = STAT_TOO_MANY;
                    n_too_many++;
                end
                else
                begin
                    lo = 0;
                    hi = int'(c.rev_count) - 1;
                    while (lo < hi)
                    begin
                        sa = shadow_head + 7'(lo);
                        sb = shadow_head + 7'(hi);
                        tmp = shadow_entries[sa];
                        shadow_entries[sa] = shadow_entries[sb];
                        shadow_entries[sb] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            default:
            begin
                n_nop++;
            end
        endcase
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        v.head_valid = (shadow_count != 0);
        v.head_value = (shadow_count != 0) ? shadow_entries[shadow_head] : '0;
        v.occupancy = COUNT_W'(shadow_count);
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatches < 20)
            $display("mismatch at result %0d: %s is %h, expected %h",
                     views_checked, what, got, exp_val);
        mismatches++;
    endtask

    // Planning keeps only the occupancy so that the stimulus can steer toward
    // full and empty; the words themselves are predicted when accepted.
    task automatic push_cmd(input logic [ACTION_W-1:0] action,
                            input logic [VALUE_W-1:0] value, input int k);
        pending_cmds.push_back({action, value, COUNT_W'(k)});
        if (action == ACT_ENQ && plan_count < DEPTH)
            plan_count++;
        else if (action == ACT_DEQ && plan_count > 0)
            plan_count--;
    endtask

    function automatic logic [VALUE_W-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_reverse_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return $urandom_range(0, (plan_count < 16) ? plan_count : 16);
        else if (r < 16)
            return plan_count;
        else
            return $urandom_range(plan_count + 1, 255);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cmd_if.action <= ACT_ENQ;
            cmd_if.entry_value <= '0;
            cmd_if.reverse_count <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
                expected_views.push_back(apply_command({cmd_if.action,
                    cmd_if.entry_value, cmd_if.reverse_count}));
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (gap_left != 0 || pending_cmds.size() == 0)
                begin
                    cmd_if.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    issue_cmd = pending_cmds.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.action <= issue_cmd.action;
                    cmd_if.entry_value <= issue_cmd.value;
                    cmd_if.reverse_count <= issue_cmd.rev_count;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Twice in the run the receiver backs off for a long stretch, so that the
    // unit fills and holds its command input while words keep being offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && views_checked >= 250 * (holds_done + 1))
        begin
            hold_left <= LONG_HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rx_cycle <= '0;
            views_checked <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rsp_if.valid && rsp_if.ready)
            begin
                views_checked <= views_checked + 1;
                if (expected_views.size() == 0)
                    report_mismatch("unexpected word, head_value", rsp_if.head_value, '0);
                else
                begin
                    want = expected_views.pop_front();
                    if (rsp_if.head_valid !== want.head_valid)
                        report_mismatch("head_valid", 64'(rsp_if.head_valid),
                                        64'(want.head_valid));
                    if (rsp_if.head_value !== want.head_value)
                        report_mismatch("head_value", rsp_if.head_value, want.head_value);
                    if (rsp_if.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 64'(rsp_if.occupancy),
                                        64'(want.occupancy));
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
                end
            end
            case (rx_cycle[9:8])
                2'd0: rx_go = 1'b1;
                2'd1: rx_go = ($urandom_range(0, 3) != 0);
                2'd2: rx_go = (rx_cycle[2:0] != 3'd0) && (rx_cycle[2:0] != 3'd5);
                default: rx_go = (rx_cycle[4:3] != 2'b11);
            endcase
            rsp_if.ready <= rx_go && (hold_left == 0);
        end
    end

    initial
    begin : stimulus
        int kind;
        int n;
        rst_n <= 1'b0;

        // Empty queue corner cases, then a few entries with extreme values.
        push_cmd(ACT_DEQ, '0, 0);
        push_cmd(ACT_REV, '0, 0);
        push_cmd(ACT_REV, '0, 1);
        push_cmd(ACT_REV, '1, 255);
        push_cmd(ACT_NONE, '1, 255);
        push_cmd(ACT_ENQ, '0, 0);
        push_cmd(ACT_REV, '0, 1);
        push_cmd(ACT_ENQ, '1, 0);
        push_cmd(ACT_ENQ, 64'h5555_5555_5555_5555, 0);
        push_cmd(ACT_ENQ, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        push_cmd(ACT_REV, '0, 2);
        push_cmd(ACT_REV, '0, 4);
        push_cmd(ACT_REV, '0, 5);
        push_cmd(ACT_REV, '0, 3);
        push_cmd(ACT_NONE, '0, 0);
        push_cmd(ACT_DEQ, '0, 0);
        push_cmd(ACT_DEQ, '0, 0);
        push_cmd(ACT_DEQ, '0, 0);
        push_cmd(ACT_DEQ, '0, 0);
        push_cmd(ACT_DEQ, '0, 0);
        push_cmd(ACT_ENQ, pick_entry(), 0);
        push_cmd(ACT_DEQ, '0, 0);

        // The first random episode always fills the queue to the brim.
        while (pending_cmds.size() < 680)
        begin
            kind = (pending_cmds.size() < 30) ? 9 : $urandom_range(0, 9);
            if (kind <= 5)
            begin
                n = $urandom_range(20, 40);
                repeat (n)
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8: push_cmd(ACT_ENQ, pick_entry(), 0);
                        9, 10, 11, 12, 13: push_cmd(ACT_DEQ, pick_entry(), 0);
                        14, 15, 16, 17, 18: push_cmd(ACT_REV, pick_entry(),
                                                     pick_reverse_count());
                        default: push_cmd(ACT_NONE, pick_entry(), $urandom_range(0, 255));
                    endcase
                end
            end
            else if (kind <= 7)
            begin
                n = plan_count + $urandom_range(1, 3);
                repeat (n)
                    push_cmd(ACT_DEQ, pick_entry(), $urandom_range(0, 255));
            end
            else
            begin
                while (plan_count < DEPTH)
                    push_cmd(ACT_ENQ, pick_entry(), $urandom_range(0, 255));
                repeat ($urandom_range(1, 3))
                    push_cmd(ACT_ENQ, pick_entry(), 0);
                push_cmd(ACT_REV, '0, DEPTH);
                push_cmd(ACT_REV, '0, DEPTH + 1);
                repeat (2)
                    push_cmd(ACT_REV, '0, pick_reverse_count());
                repeat ($urandom_range(10, 40))
                    push_cmd(ACT_DEQ, '0, 0);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_if.valid)
            @(negedge clk);
        while (expected_views.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d results checked: %0d enqueues (%0d refused when full), %0d dequeues (%0d on empty)",
                 views_checked, n_enq, n_full, n_deq, n_empty);
        $display("%0d reverses (%0d with count too large), %0d ignored words, peak occupancy %0d",
                 n_rev, n_too_many, n_nop, peak_count);
        if (mismatches == 0 && expected_views.size() == 0)
            $display("[fifo_with_prefix_reverse_unit] OK");
        else
            $display("[fifo_with_prefix_reverse_unit] ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d results still expected", expected_views.size());
        $display("[fifo_with_prefix_reverse_unit] ERROR");
        $finish;
    end

endmodule
